// ----- rtl/core/cmr_pkg.sv -----
package cmr_pkg;

	// buffer geometry
	localparam int BUF_DEPTH = 64;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int MAX_OUT   = 64;
	localparam int CNT_W     = 8;

	// field widths
	localparam int ID_W      = 29;
	localparam int BASE_W    = 21;
	localparam int LEN_W     = 7;
	localparam int SEQ_W     = 8;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 3;

	// frame markers and sequence numbers
	localparam logic [BYTE_W-1:0] START_MARK = 8'h3C;
	localparam logic [BYTE_W-1:0] END_MARK   = 8'h55;
	localparam logic [SEQ_W-1:0]  START_SEQ  = 8'h01;
	localparam logic [SEQ_W-1:0]  MID_FIRST  = 8'h02;
	localparam logic [SEQ_W-1:0]  MID_LAST   = 8'h05;
	localparam logic [SEQ_W-1:0]  END_SEQ    = 8'hFF;

	// register reset values
	localparam logic [BASE_W-1:0] ID_BASE_RST = 21'h1911F0;
	localparam logic [LEN_W-1:0]  EXP_LEN_RST = 7'd46;

	// register indexes
	localparam logic REG_ID_BASE = 1'b0;
	localparam logic REG_EXP_LEN = 1'b1;

	typedef logic [7:0][BYTE_W-1:0] frame_bytes_t;

	typedef enum logic [1:0] {
		CLS_REJECT = 2'd0,
		CLS_START  = 2'd1,
		CLS_MID    = 2'd2,
		CLS_END    = 2'd3
	} frame_cls_t;

	// decoded frame: class and range of data bytes to append
	typedef struct packed {
		frame_cls_t       cls;
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W-1:0] last_idx;
	} frame_info_t;

endpackage

// ----- rtl/core/cmr_byte_ram.sv -----
module cmr_byte_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [cmr_pkg::ADDR_W-1:0]   waddr,
	input  logic [cmr_pkg::BYTE_W-1:0]   wdata,
	input  logic                         re,
	input  logic [cmr_pkg::ADDR_W-1:0]   raddr,
	output logic [cmr_pkg::BYTE_W-1:0]   rdata_q
);

	logic [cmr_pkg::BYTE_W-1:0] mem_q [cmr_pkg::BUF_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/cmr_frame_dec.sv -----
module cmr_frame_dec (
	input  logic [cmr_pkg::ID_W-1:0]   can_id,
	input  cmr_pkg::frame_bytes_t      data_bytes,
	input  logic [cmr_pkg::BASE_W-1:0] id_base,
	output cmr_pkg::frame_info_t       info
);

	logic                       id_match;
	logic [cmr_pkg::SEQ_W-1:0]  seq_num;

	assign id_match = (can_id[cmr_pkg::ID_W-1:cmr_pkg::SEQ_W] == id_base);
	assign seq_num  = can_id[cmr_pkg::SEQ_W-1:0];

	// classify frame by sequence number and marker byte
	always_comb begin
		info.cls       = cmr_pkg::CLS_REJECT;
		info.first_idx = 3'd0;
		info.last_idx  = 3'd7;
		if (id_match) begin
			if (seq_num == cmr_pkg::START_SEQ) begin
				if (data_bytes[0] == cmr_pkg::START_MARK) begin
					info.cls = cmr_pkg::CLS_START;
				end
				info.first_idx = 3'd1;
			end else if (seq_num >= cmr_pkg::MID_FIRST && seq_num <= cmr_pkg::MID_LAST) begin
				info.cls = cmr_pkg::CLS_MID;
			end else if (seq_num == cmr_pkg::END_SEQ) begin
				if (data_bytes[7] == cmr_pkg::END_MARK) begin
					info.cls = cmr_pkg::CLS_END;
				end
				info.last_idx = 3'd6;
			end
		end
	end

endmodule

// ----- rtl/core/cmr_seq.sv -----
module cmr_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	// frame request
	input  logic                         s_valid,
	output logic                         s_ready,
	input  cmr_pkg::frame_info_t         info,
	input  cmr_pkg::frame_bytes_t        data_bytes,
	input  logic [cmr_pkg::LEN_W-1:0]    expected_len,
	// buffer ram
	output logic                         ram_we,
	output logic [cmr_pkg::ADDR_W-1:0]   ram_waddr,
	output logic [cmr_pkg::BYTE_W-1:0]   ram_wdata,
	output logic                         ram_re,
	output logic [cmr_pkg::ADDR_W-1:0]   ram_raddr,
	input  logic [cmr_pkg::BYTE_W-1:0]   ram_rdata,
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata,  // accepted, length_error, payload_byte
	output logic                         m_tuser,  // kind
	output logic                         m_tlast
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_WRITE   = 6'b000010,
		ST_CHECK   = 6'b000100,
		ST_STATUS  = 6'b001000,
		ST_RD_ADDR = 6'b010000,
		ST_RD_DATA = 6'b100000
	} state_t;

	state_t                      state_q;
	cmr_pkg::frame_bytes_t       bytes_q;
	cmr_pkg::frame_cls_t         cls_q;
	logic [cmr_pkg::IDX_W-1:0]   bi_q;
	logic [cmr_pkg::IDX_W-1:0]   last_idx_q;
	logic [cmr_pkg::CNT_W-1:0]   fill_q;
	logic [cmr_pkg::CNT_W-1:0]   rd_cnt_q;
	logic                        st_acc_q;
	logic                        st_lerr_q;

	logic                        out_valid_q;
	logic                        out_kind_q;
	logic                        out_acc_q;
	logic                        out_lerr_q;
	logic [cmr_pkg::BYTE_W-1:0]  out_byte_q;
	logic                        out_last_q;

	logic                        in_req;
	logic                        out_free;
	logic                        fill_room;
	logic                        len_ok;
	logic                        rd_last;
	logic [cmr_pkg::CNT_W:0]     fill_ext;

	assign s_ready   = (state_q == ST_IDLE);
	assign in_req    = s_valid && s_ready;
	assign out_free  = !out_valid_q || m_tready;

	// byte append and length check against the fill count
	assign fill_ext  = {1'b0, fill_q};
	assign fill_room = fill_ext < (cmr_pkg::CNT_W+1)'(cmr_pkg::BUF_DEPTH);
	assign len_ok    = (fill_q == {1'b0, expected_len}) && (fill_q != '0)
		&& (fill_ext <= (cmr_pkg::CNT_W+1)'(cmr_pkg::BUF_DEPTH))
		&& (fill_ext <= (cmr_pkg::CNT_W+1)'(cmr_pkg::MAX_OUT));
	assign rd_last   = ((rd_cnt_q + 1'b1) == fill_q);

	assign ram_we    = (state_q == ST_WRITE) && fill_room;
	assign ram_waddr = fill_q[cmr_pkg::ADDR_W-1:0];
	assign ram_wdata = bytes_q[bi_q];
	assign ram_re    = (state_q == ST_RD_ADDR);
	assign ram_raddr = rd_cnt_q[cmr_pkg::ADDR_W-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			bi_q       <= '0;
			last_idx_q <= '0;
			rd_cnt_q   <= '0;
			cls_q      <= cmr_pkg::CLS_REJECT;
			st_acc_q   <= 1'b0;
			st_lerr_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						cls_q      <= info.cls;
						bi_q       <= info.first_idx;
						last_idx_q <= info.last_idx;
						st_acc_q   <= 1'b0;
						st_lerr_q  <= 1'b0;
						if (info.cls == cmr_pkg::CLS_START) begin
							fill_q <= '0;
						end
						if (info.cls == cmr_pkg::CLS_REJECT) begin
							state_q <= ST_STATUS;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					if (fill_q != '1) begin
						fill_q <= fill_q + 1'b1;
					end
					if (bi_q == last_idx_q) begin
						if (cls_q == cmr_pkg::CLS_END) begin
							state_q <= ST_CHECK;
						end else begin
							st_acc_q <= 1'b1;
							state_q  <= ST_STATUS;
						end
					end else begin
						bi_q <= bi_q + 1'b1;
					end
				end
				ST_CHECK: begin
					rd_cnt_q <= '0;
					if (len_ok) begin
						state_q <= ST_RD_ADDR;
					end else begin
						st_lerr_q <= 1'b1;
						state_q   <= ST_STATUS;
					end
				end
				ST_STATUS: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					if (out_free) begin
						if (rd_last) begin
							state_q <= ST_IDLE;
						end else begin
							rd_cnt_q <= rd_cnt_q + 1'b1;
							state_q  <= ST_RD_ADDR;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// frame byte capture
	always_ff @(posedge clk) begin
		if (in_req) begin
			bytes_q <= data_bytes;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_STATUS || state_q == ST_RD_DATA) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_STATUS) begin
				out_kind_q <= 1'b0;
				out_acc_q  <= st_acc_q;
				out_lerr_q <= st_lerr_q;
				out_byte_q <= '0;
				out_last_q <= 1'b1;
			end else if (state_q == ST_RD_DATA) begin
				out_kind_q <= 1'b1;
				out_acc_q  <= 1'b1;
				out_lerr_q <= 1'b0;
				out_byte_q <= ram_rdata;
				out_last_q <= rd_last;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'd0, out_byte_q, out_lerr_q, out_acc_q};

endmodule

// ----- rtl/core/can_multiframe_reassembler_top.sv -----
// status result: a start or middle frame is written into the buffer, then its status is registered out
// end frame: 7 byte writes and a length check, then the payload is read back from the buffer, with a read
//   address step and a read data step per payload byte; a length error or a rejected frame gives a status
// throughput: one frame at a time, a new frame is taken only while the sequencer is idle; output stalls hold it
// reset: asynchronous, clears fill count, sequencer, output valid and configuration registers to their defaults;
// buffer contents are undefined until written and are not cleared
module can_multiframe_reassembler_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [20:0] cfg_wdata,
	// frame stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // can_id, data_byte_0 .. data_byte_7
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // accepted, length_error, payload_byte
	output logic        m_tuser,  // kind
	output logic        m_tlast
);

	logic [cmr_pkg::BASE_W-1:0]  id_base_q;
	logic [cmr_pkg::LEN_W-1:0]   exp_len_q;
	logic [cmr_pkg::ID_W-1:0]    can_id;
	cmr_pkg::frame_bytes_t       data_bytes;
	cmr_pkg::frame_info_t        info;

	logic                        ram_we;
	logic [cmr_pkg::ADDR_W-1:0]  ram_waddr;
	logic [cmr_pkg::BYTE_W-1:0]  ram_wdata;
	logic                        ram_re;
	logic [cmr_pkg::ADDR_W-1:0]  ram_raddr;
	logic [cmr_pkg::BYTE_W-1:0]  ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q <= cmr_pkg::ID_BASE_RST;
			exp_len_q <= cmr_pkg::EXP_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				cmr_pkg::REG_ID_BASE: id_base_q <= cfg_wdata;
				cmr_pkg::REG_EXP_LEN: exp_len_q <= cfg_wdata[cmr_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// unpack frame fields
	assign can_id = s_tdata[cmr_pkg::ID_W-1:0];
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			data_bytes[i] = s_tdata[cmr_pkg::ID_W + cmr_pkg::BYTE_W*i +: cmr_pkg::BYTE_W];
		end
	end

	cmr_frame_dec u_dec (
		.can_id     (can_id),
		.data_bytes (data_bytes),
		.id_base    (id_base_q),
		.info       (info)
	);

	cmr_byte_ram u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr   (ram_raddr),
		.rdata_q (ram_rdata)
	);

	cmr_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_valid      (s_tvalid),
		.s_ready      (s_tready),
		.info         (info),
		.data_bytes   (data_bytes),
		.expected_len (exp_len_q),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

endmodule
